// ===== rtl/core/lruchc_pkg.sv =====
package lruchc_pkg;

   localparam int KEY_W           = 64;
   localparam int HIT_W           = 32;
   localparam int CAP_W           = 5;
   localparam int ENTRIES_DEFAULT = 16;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic scan;
      logic update;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_done;
   } dp_status_type;

endpackage

// ===== rtl/core/lruchc_ctrl.sv =====
module lruchc_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   output lruchc_pkg::dp_cmd_type    cmd,
   input  lruchc_pkg::dp_status_type status
);
   import lruchc_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_UPDATE = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign cmd.load   = (state_ff == ST_IDLE) && start;
   assign cmd.scan   = (state_ff == ST_SCAN);
   assign cmd.update = (state_ff == ST_UPDATE);

endmodule

// ===== rtl/core/lruchc_dpath.sv =====
module lruchc_dpath #(
   parameter int ENTRIES = lruchc_pkg::ENTRIES_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic signed [lruchc_pkg::KEY_W-1:0] req_key,
   input  logic                               csr_we,
   input  logic [lruchc_pkg::CAP_W-1:0]       csr_wdata,
   input  lruchc_pkg::dp_cmd_type             cmd,
   output lruchc_pkg::dp_status_type          status,
   output logic                               rsp_valid,
   output logic                               rsp_hit,
   output logic [lruchc_pkg::HIT_W-1:0]       rsp_hits_so_far
);
   import lruchc_pkg::*;

   localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W  = $clog2(ENTRIES + 1);
   localparam int RANK_W = IDX_W;
   localparam int EW     = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   // Key store: written in the update cycle, read one entry per scan cycle.
   logic [KEY_W-1:0] key_mem [ENTRIES];

   logic [RANK_W-1:0] rank_ff [ENTRIES];
   logic [RANK_W-1:0] rank_in [ENTRIES];

   logic [CAP_W-1:0]  capacity_ff;
   logic [CNT_W-1:0]  fill_ff;
   logic [HIT_W-1:0]  hit_total_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [KEY_W-1:0]  rd_key_ff;
   logic [CNT_W-1:0]  scan_idx_ff;
   logic [CNT_W-1:0]  cmp_idx_ff;
   logic              cmp_vld_ff;
   logic              found_ff;
   logic [IDX_W-1:0]  slot_ff;
   logic [RANK_W-1:0] hit_rank_ff;
   logic [RANK_W-1:0] oldest_ff;
   logic [IDX_W-1:0]  oldest_slot_ff;
   logic              rsp_valid_ff;
   logic              rsp_hit_ff;

   logic [EW-1:0]     cap_eff;
   logic [EW-1:0]     cap_ext;
   logic [EW-1:0]     fill_ext;
   logic              cap_nz;
   logic              do_fill;
   logic              do_write;
   logic [IDX_W-1:0]  wr_slot;
   logic [RANK_W-1:0] age_limit;
   logic [RANK_W-1:0] cmp_rank;
   logic              key_match;
   logic              cmp_last;

   assign cap_ext  = EW'(capacity_ff);
   assign cap_eff  = (cap_ext > EW'(ENTRIES)) ? EW'(ENTRIES) : cap_ext;
   assign fill_ext = EW'(fill_ff);
   assign cap_nz   = (cap_eff != '0);

   assign cmp_rank  = rank_ff[cmp_idx_ff[IDX_W-1:0]];
   assign key_match = (rd_key_ff == key_ff);
   assign cmp_last  = ((cmp_idx_ff + CNT_W'(1)) == fill_ff);

   assign status.scan_done = (fill_ff == '0) || (cmp_vld_ff && (key_match || cmp_last));

   // A miss below capacity takes the next free slot and ages every filled entry.
   assign do_fill   = !found_ff && cap_nz && (fill_ext < cap_eff);
   assign do_write  = cmd.update && (found_ff || cap_nz);
   assign age_limit = found_ff ? hit_rank_ff : oldest_ff;

   always_comb begin
      if (found_ff) begin
         wr_slot = slot_ff;
      end else if (do_fill) begin
         wr_slot = fill_ff[IDX_W-1:0];
      end else begin
         wr_slot = oldest_slot_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         rank_in[i] = rank_ff[i];
         if ((CNT_W'(i) < fill_ff) && (do_fill || (rank_ff[i] < age_limit))) begin
            rank_in[i] = rank_ff[i] + RANK_W'(1);
         end
         if (IDX_W'(i) == wr_slot) begin
            rank_in[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_write && !found_ff) begin
         key_mem[wr_slot] <= key_ff;
      end
      rd_key_ff <= key_mem[scan_idx_ff[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAP_RESET;
         fill_ff      <= '0;
         hit_total_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= cmd.update;
         if (csr_we) begin
            capacity_ff <= csr_wdata;
            fill_ff     <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
               rank_ff[i] <= '0;
            end
         end else if (do_write) begin
            for (int i = 0; i < ENTRIES; i++) begin
               rank_ff[i] <= rank_in[i];
            end
            if (do_fill) begin
               fill_ff <= fill_ff + CNT_W'(1);
            end
            if (found_ff && !(&hit_total_ff)) begin
               hit_total_ff <= hit_total_ff + HIT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_vld_ff <= 1'b0;
      end else if (cmd.load) begin
         cmp_vld_ff <= 1'b0;
      end else begin
         cmp_vld_ff <= cmd.scan && (scan_idx_ff < fill_ff);
      end
   end

   // Scan: the key memory is read into a register in the cycle before the compare.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff         <= req_key;
         scan_idx_ff    <= '0;
         cmp_idx_ff     <= '0;
         found_ff       <= 1'b0;
         slot_ff        <= '0;
         hit_rank_ff    <= '0;
         oldest_ff      <= '0;
         oldest_slot_ff <= '0;
      end else if (cmd.scan) begin
         if (scan_idx_ff < fill_ff) begin
            scan_idx_ff <= scan_idx_ff + CNT_W'(1);
         end
         cmp_idx_ff <= scan_idx_ff;
         if (cmp_vld_ff) begin
            if (key_match) begin
               found_ff    <= 1'b1;
               slot_ff     <= cmp_idx_ff[IDX_W-1:0];
               hit_rank_ff <= cmp_rank;
            end else if ((cmp_idx_ff == '0) || (cmp_rank > oldest_ff)) begin
               oldest_ff      <= cmp_rank;
               oldest_slot_ff <= cmp_idx_ff[IDX_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         rsp_hit_ff <= found_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_hits_so_far = hit_total_ff;

endmodule

// ===== rtl/core/lru_cache_hit_counter.sv =====
// Fully associative LRU cache of 64-bit keys that counts hits. A key is taken when start is
// high and busy is low; one result word follows, shown on the rsp_ ports for exactly one
// cycle while rsp_valid is high, and the receiver cannot stall it. On a miss an access scans all
// fill occupied entries before the result strobe (fill is the number of occupied entries, at most
// ENTRIES), and on a hit in entry j it stops after entry j, because the key memory is
// searched one entry per cycle through its single read port, followed by the update state.
// A new key can be accepted in the cycle that the previous result is strobed. Writing the
// capacity register empties the cache but keeps the hit total; write it only while busy is
// low.
module lru_cache_hit_counter #(
   parameter int ENTRIES = lruchc_pkg::ENTRIES_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic signed [lruchc_pkg::KEY_W-1:0] req_key,
   input  logic                               csr_we,
   input  logic [lruchc_pkg::CAP_W-1:0]       csr_wdata,
   output logic                               rsp_valid,
   output logic                               rsp_hit,
   output logic [lruchc_pkg::HIT_W-1:0]       rsp_hits_so_far
);
   import lruchc_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   lruchc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .cmd    (cmd),
      .status (status)
   );

   lruchc_dpath #(
      .ENTRIES (ENTRIES)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_key         (req_key),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_hit         (rsp_hit),
      .rsp_hits_so_far (rsp_hits_so_far)
   );

endmodule

// ===== rtl/core/lruchc_checker.sv =====
module lruchc_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic                         rsp_valid,
   input logic                         rsp_hit,
   input logic [lruchc_pkg::HIT_W-1:0] rsp_hits_so_far
);
   import lruchc_pkg::*;

   // Every accepted word keeps the block busy for at least the scan and update cycles.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not make the block busy");

   // A result word only ends a busy period.
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(reset)) |-> ($past(busy) && !busy))
      else $error("result word without a preceding busy period");

   // The hit total moves only with a result word.
   a_total_moves_with_rsp: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(rsp_hits_so_far)) |-> (rsp_valid && rsp_hit))
      else $error("hit total changed outside a hit result");

   // A hit always leaves a nonzero total.
   a_hit_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit) |-> (rsp_hits_so_far != '0))
      else $error("hit reported with a zero total");

endmodule

bind lru_cache_hit_counter lruchc_checker u_lruchc_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_hit         (rsp_hit),
   .rsp_hits_so_far (rsp_hits_so_far)
);

// ===== dv/lru_cache_hit_counter_test.sv =====
module lru_cache_hit_counter_test;
   import lruchc_pkg::*;

   localparam int ENTRIES = ENTRIES_DEFAULT;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS = 250;
   localparam int MAX_GAP = 10;
   localparam int SETTLE_CYCLES = 40;
   localparam int REPORT_LIMIT = 10;
   localparam logic [CAP_W-1:0] CAP_OFF = '0;
   localparam logic [CAP_W-1:0] CAP_TOP = '1;
   localparam logic [HIT_W-1:0] HIT_TOP = '1;
   localparam logic [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
   localparam logic [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

   typedef struct {
      logic             hit;
      logic [HIT_W-1:0] total;
   } access_word_type;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic signed [KEY_W-1:0]   req_key;
   logic                      csr_we;
   logic [CAP_W-1:0]          csr_wdata;
   logic                      rsp_valid;
   logic                      rsp_hit;
   logic [HIT_W-1:0]          rsp_hits_so_far;

   // Shadow copy of the cache contents used to predict every access.
   logic [KEY_W-1:0] cached_key [ENTRIES];
   int               age_rank [ENTRIES];
   int               filled;
   logic [HIT_W-1:0] hit_count;
   logic [CAP_W-1:0] capacity_reg;

   access_word_type expected_words[$];
   int              mismatches = 0;

   lru_cache_hit_counter #(.ENTRIES(ENTRIES)) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_key         (req_key),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_valid),
      .rsp_hit         (rsp_hit),
      .rsp_hits_so_far (rsp_hits_so_far)
   );

   always #4 clock = ~clock;

   initial begin
      #(8 * 400000);
      $display("lru_cache_hit_counter_test: FAIL");
      $finish;
   end

   // Every filled entry younger than limit moves one step older.
   function automatic void age_entries(input int limit);
      for (int i = 0; i < filled && i < ENTRIES; i++)
         if (age_rank[i] < limit)
            age_rank[i]++;
   endfunction

   function automatic void empty_shadow();
      for (int i = 0; i < ENTRIES; i++)
         age_rank[i] = 0;
      filled = 0;
   endfunction

   function automatic access_word_type lru_predict(input logic [KEY_W-1:0] key);
      int              lim;
      int              used;
      int              slot;
      int              oldest;
      logic            found;
      access_word_type w;
      lim = (capacity_reg > ENTRIES) ? ENTRIES : int'(capacity_reg);
      used = (filled < lim) ? filled : lim;
      slot = 0;
      found = 1'b0;
      for (int i = 0; i < used && !found; i++)
         if (cached_key[i] == key) begin
            slot = i;
            found = 1'b1;
         end
      if (found) begin
         age_entries(age_rank[slot]);
         age_rank[slot] = 0;
         if (hit_count != HIT_TOP)
            hit_count++;
      end else if (lim != 0) begin
         if (filled < lim) begin
            slot = filled;
            age_entries(32'h10000);
            filled++;
         end else begin
            oldest = 0;
            for (int i = 0; i < used; i++)
               if (age_rank[i] > oldest || i == 0) begin
                  oldest = age_rank[i];
                  slot = i;
               end
            age_entries(oldest);
         end
         cached_key[slot] = key;
         age_rank[slot] = 0;
      end
      w.hit = found;
      w.total = hit_count;
      return w;
   endfunction

   function automatic logic [KEY_W-1:0] random_key();
      return {$urandom, $urandom};
   endfunction

   always @(posedge clock) begin
      access_word_type w;
      if (!reset && rsp_valid) begin
         if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected result word: hit %0b hits_so_far %0d",
                        rsp_hit, rsp_hits_so_far);
         end else begin
            w = expected_words.pop_front();
            if (rsp_hit !== w.hit || rsp_hits_so_far !== w.total) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("result word mismatch: hit exp %0b got %0b, hits_so_far exp %0d got %0d",
                           w.hit, rsp_hit, w.total, rsp_hits_so_far);
            end
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after the key was taken.
   task automatic send_key(input logic [KEY_W-1:0] key, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start <= 1'b1;
      req_key <= key;
      do
         @(posedge clock);
      while (busy);
      expected_words.push_back(lru_predict(key));
      @(negedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (expected_words.size() != 0 || busy)
         @(negedge clock);
   endtask

   task automatic set_capacity(input logic [CAP_W-1:0] value);
      drain();
      repeat (3) @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      capacity_reg = value;
      empty_shadow();
   endtask

   task automatic test_extreme_keys();
      send_key(KEY_MIN, $urandom_range(0, MAX_GAP));
      send_key(KEY_MAX, $urandom_range(0, MAX_GAP));
      send_key('0, 0);
      send_key('1, 0);
      send_key(KEY_MIN, $urandom_range(0, MAX_GAP));
      send_key('1, 0);
   endtask

   // With two entries the older key must be the one replaced.
   task automatic test_lru_replacement();
      logic [KEY_W-1:0] a, b, c;
      a = random_key();
      b = a ^ 64'h1;
      c = ~a;
      set_capacity(CAP_W'(2));
      send_key(a, 0);
      send_key(b, 0);
      send_key(a, 1);
      send_key(c, 0);
      send_key(b, 2);
      send_key(c, 0);
   endtask

   task automatic test_caching_disabled();
      set_capacity(CAP_OFF);
      send_key(64'd5, 0);
      send_key(64'd5, 0);
      send_key(64'd5, 3);
   endtask

   task automatic test_capacity_above_entries();
      logic [KEY_W-1:0] k;
      k = random_key();
      set_capacity(CAP_TOP);
      send_key(k, 0);
      send_key(~k, 0);
      send_key(k, 0);
   endtask

   // Keys mostly come from a small pool so that hits and replacements both happen.
   task automatic test_random_traffic();
      logic [KEY_W-1:0] pool[$];
      logic [KEY_W-1:0] key;
      logic [CAP_W-1:0] cap;
      int               burst;
      int               gap;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: cap = CAP_TOP;
            1: cap = CAP_W'(1);
            2: cap = CAP_OFF;
            3: cap = CAP_W'(ENTRIES);
            4: cap = CAP_W'(ENTRIES + 1);
            default: cap = CAP_W'($urandom_range(0, (1 << CAP_W) - 1));
         endcase
         set_capacity(cap);
         pool.delete();
         repeat ($urandom_range(1, 24)) pool.push_back(random_key());
         burst = 0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 9) == 0)
               key = random_key();
            else
               key = pool[$urandom_range(0, pool.size() - 1)];
            if ($urandom_range(0, 19) == 0)
               pool[$urandom_range(0, pool.size() - 1)] = random_key();
            if (burst == 0 && $urandom_range(0, 19) == 0)
               burst = $urandom_range(10, 30);
            if (burst > 0) begin
               burst--;
               gap = 0;
            end else begin
               gap = $urandom_range(0, MAX_GAP);
            end
            if ($urandom_range(0, 49) == 0)
               drain();
            send_key(key, gap);
         end
      end
   endtask

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_key <= '0;
      csr_we <= 1'b0;
      csr_wdata <= '0;
      capacity_reg = CAP_RESET;
      hit_count = '0;
      empty_shadow();
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_extreme_keys();
      test_lru_replacement();
      test_caching_disabled();
      test_capacity_above_entries();
      test_random_traffic();

      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatches == 0 && expected_words.size() == 0)
         $display("lru_cache_hit_counter_test: PASS");
      else
         $display("lru_cache_hit_counter_test: FAIL");
      $finish;
   end

endmodule
